@@ rtl/feedback_delay_reverb_macros.svh @@
// ----------------------------------------------------------------------------
// Feedback delay reverb assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_DELAY_REVERB_MACROS_SVH
`define FEEDBACK_DELAY_REVERB_MACROS_SVH

// Same-cycle implication, ignored while reset is high
`define FDR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high
`define FDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked around reset
`define FDR_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fdr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback delay reverb package
// Payload types, configuration register map and fixed constants.
// ----------------------------------------------------------------------------
package fdr_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int CHAN_FIELD_W = 3;
  localparam int LEN_W       = 17;
  localparam int GAIN_W      = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;

  // Queue depths between the parts of the block
  localparam int JOB_QUEUE_DEPTH    = 2;
  localparam int RESULT_QUEUE_DEPTH = 4;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_GAIN    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_ENABLE = 2'd3;

  localparam logic [LEN_W-1:0] DELAY_LENGTH_RESET = 17'd1;

  typedef struct packed {
    logic                       op;
    logic [CHAN_FIELD_W-1:0]    channel_in;
    logic signed [SAMPLE_W-1:0] sample_in;
  } item_t;

  typedef struct packed {
    logic [CHAN_FIELD_W-1:0]    channel_out;
    logic signed [SAMPLE_W-1:0] sample_out;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0]  delay_length;
    logic [GAIN_W-1:0] decay_gain;
    logic [GAIN_W-1:0] feedback_gain;
    logic              effect_enable;
  } cfg_t;

  // Classified sample transaction handed from front to back
  typedef struct packed {
    logic                       fresh;
    logic [CHAN_FIELD_W-1:0]    channel;
    logic signed [SAMPLE_W-1:0] sample;
  } job_t;

endpackage

@@ rtl/fdr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
module fdr_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/fdr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out buffer in flops; push and pop may happen together.
// ----------------------------------------------------------------------------
module fdr_queue #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 2,
  parameter int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full,
  output logic [CNT_W-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign pop_data = mem[rd_ptr];

  // Pointer wrap at the queue depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (32'(p) == DEPTH - 1) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/fdr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback delay reverb front end
// Accepts transactions, handles flush, tracks per-channel ring heads and
// written-prefix counts, and queues sample jobs with their store address.
// ----------------------------------------------------------------------------
module fdr_front #(
  parameter int CHANNELS  = 2,
  parameter int MAX_DELAY = 65536,
  parameter int HEAD_W    = $clog2(MAX_DELAY),
  parameter int CHAN_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  parameter int ADDR_W    = CHAN_W + HEAD_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  fdr_pkg::item_t      item,
  input  fdr_pkg::cfg_t       cfg,
  input  logic                job_full,
  output logic                job_push,
  output logic [ADDR_W-1:0]   job_addr,
  output fdr_pkg::job_t       job
);

  localparam int LEN_IW = HEAD_W + 1;

  // Ring head and count of slots written since the last flush, per channel.
  // Writes always fill a prefix of the ring, so one count marks what is live.
  logic [HEAD_W-1:0] head [CHANNELS];
  logic [LEN_IW-1:0] fill [CHANNELS];

  logic              accept;
  logic              ch_ok;
  logic [CHAN_W-1:0] chi;
  logic [LEN_IW-1:0] len;
  logic [HEAD_W-1:0] head_cur;
  logic [HEAD_W-1:0] head_use;
  logic [LEN_IW-1:0] head_inc;
  logic [HEAD_W-1:0] head_wrap;
  logic              fresh;

  assign item_stall = job_full;
  assign accept     = item_valid && !job_full;

  // Effective ring length and current slot
  always_comb begin
    chi   = item.channel_in[CHAN_W-1:0];
    ch_ok = (32'(item.channel_in) < CHANNELS);
    if (cfg.delay_length == '0) begin
      len = LEN_IW'(1);
    end else if (32'(cfg.delay_length) > MAX_DELAY) begin
      len = LEN_IW'(MAX_DELAY);
    end else begin
      len = LEN_IW'(cfg.delay_length);
    end
    head_cur  = head[chi];
    head_use  = ({1'b0, head_cur} >= len) ? '0 : head_cur;
    head_inc  = {1'b0, head_use} + LEN_IW'(1);
    head_wrap = (head_inc >= len) ? '0 : head_inc[HEAD_W-1:0];
    fresh     = ({1'b0, head_use} < fill[chi]);
  end

  assign job_push    = accept && (item.op == fdr_pkg::OP_SAMPLE) && ch_ok;
  assign job_addr    = {chi, head_use};
  assign job.fresh   = fresh;
  assign job.channel = item.channel_in;
  assign job.sample  = item.sample_in;

  // Head and fill bookkeeping; flush empties every ring at once
  always_ff @(posedge clk) begin
    if (rst || (accept && item.op == fdr_pkg::OP_FLUSH)) begin
      for (int i = 0; i < CHANNELS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else if (job_push) begin
      head[chi] <= head_wrap;
      if (!fresh) begin
        fill[chi] <= head_inc;
      end
    end
  end

endmodule

@@ rtl/fdr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback delay reverb back end
// Read-modify-write of the delay store with forwarding, gain scaling,
// saturation and a result queue toward the output port.
// ----------------------------------------------------------------------------
module fdr_back #(
  parameter int CHANNELS  = 2,
  parameter int MAX_DELAY = 65536,
  parameter int HEAD_W    = $clog2(MAX_DELAY),
  parameter int CHAN_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  parameter int ADDR_W    = CHAN_W + HEAD_W
) (
  input  logic              clk,
  input  logic              rst,
  input  fdr_pkg::cfg_t     cfg,
  input  logic              job_empty,
  output logic              job_pop,
  input  logic [ADDR_W-1:0] job_addr,
  input  fdr_pkg::job_t     job,
  output logic              result_valid,
  input  logic              result_stall,
  output fdr_pkg::result_t  result
);

  localparam int SW        = fdr_pkg::SAMPLE_W;
  localparam int RAM_DEPTH = CHANNELS * (2 ** HEAD_W);
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam int OUT_DEPTH = fdr_pkg::RESULT_QUEUE_DEPTH;
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);
  localparam int CREDIT_W  = OCNT_W + 1;

  // d * gain in Q1.15, rounded half up (add half, floor)
  function automatic logic signed [SW+1:0] scale_q15(
    input logic signed [SW-1:0]             d,
    input logic [fdr_pkg::GAIN_W-1:0]      g
  );
    logic signed [SW+fdr_pkg::GAIN_W:0] p;
    p = d * $signed({1'b0, g});
    p = p + (SW + fdr_pkg::GAIN_W + 1)'(16384);
    return p[SW+fdr_pkg::GAIN_W:15];
  endfunction

  // Clamp to the signed 24-bit sample range
  function automatic logic signed [SW-1:0] sat24(input logic signed [SW+2:0] v);
    logic signed [SW-1:0] r;
    if (v > $signed((SW + 3)'(8388607))) begin
      r = 24'sh7FFFFF;
    end else if (v < -$signed((SW + 3)'(8388608))) begin
      r = 24'sh800000;
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // Read stage result
  logic              v1;
  logic [ADDR_W-1:0] addr1;
  fdr_pkg::job_t     job1;
  logic [SW-1:0]     rdata;

  // Write stage
  logic              v2;
  logic [ADDR_W-1:0] addr2;
  logic [SW-1:0]     w2;
  fdr_pkg::result_t  res2;

  // Last completed write, still unseen by a read issued in the same cycle
  logic              w3v;
  logic [ADDR_W-1:0] addr3;
  logic [SW-1:0]     w3;

  logic signed [SW-1:0]   d;
  logic signed [SW+1:0]   sc_decay;
  logic signed [SW+1:0]   sc_fb;
  logic signed [SW-1:0]   y;
  logic signed [SW-1:0]   w;
  logic [OCNT_W-1:0]      out_count;
  logic                   out_empty;
  logic [$bits(fdr_pkg::result_t)-1:0] out_data;

  // Issue a read only when the result queue has room for everything in flight
  assign job_pop = !job_empty &&
                   (({1'b0, out_count} + CREDIT_W'(v1) + CREDIT_W'(v2))
                    < CREDIT_W'(OUT_DEPTH));

  fdr_ram #(
    .WIDTH (SW),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (v2),
    .waddr (addr2[RAM_AW-1:0]),
    .wdata (w2),
    .re    (job_pop),
    .raddr (job_addr[RAM_AW-1:0]),
    .rdata (rdata)
  );

  // Delayed value with forwarding, then mix and feedback sums
  always_comb begin
    if (!job1.fresh) begin
      d = '0;
    end else if (v2 && addr2 == addr1) begin
      d = w2;
    end else if (w3v && addr3 == addr1) begin
      d = w3;
    end else begin
      d = rdata;
    end
    sc_decay = scale_q15(d, cfg.decay_gain);
    sc_fb    = scale_q15(d, cfg.feedback_gain);
    w = sat24({{3{job1.sample[SW-1]}}, job1.sample} + {sc_fb[SW+1], sc_fb});
    if (cfg.effect_enable) begin
      y = sat24({{3{job1.sample[SW-1]}}, job1.sample} + {sc_decay[SW+1], sc_decay});
    end else begin
      y = job1.sample;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      w3v <= 1'b0;
    end else begin
      v1 <= job_pop;
      v2 <= v1;
      if (v2) begin
        w3v <= 1'b1;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (job_pop) begin
      addr1 <= job_addr;
      job1  <= job;
    end
    if (v1) begin
      addr2            <= addr1;
      w2               <= w;
      res2.channel_out <= job1.channel;
      res2.sample_out  <= y;
    end
    if (v2) begin
      addr3 <= addr2;
      w3    <= w2;
    end
  end

  // Result queue decouples the output handshake from the pipeline
  fdr_queue #(
    .WIDTH ($bits(fdr_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_result_q (
    .clk       (clk),
    .rst       (rst),
    .push      (v2),
    .push_data (res2),
    .pop       (result_valid && !result_stall),
    .pop_data  (out_data),
    .empty     (out_empty),
    .full      (),
    .count     (out_count)
  );

  assign result_valid = !out_empty;
  assign result       = fdr_pkg::result_t'(out_data);

endmodule

@@ rtl/feedback_delay_reverb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback delay reverb
// Per-channel feedback comb delay with configurable length and Q1.15 gains.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless the job queue is full, and sustains
// one result per clock while the output is not stalled. The rate is set by
// the delay-store read-modify-write: the store is one RAM with a single read
// and a single write port, and forwarding from the two most recent writes
// lets a ring of length one run every cycle. A flush resets heads and counts
// only: a per-channel count of written slots makes unwritten slots read as
// zero, so no clearing pass is needed after reset or flush.
// Change delay_length only while idle and flush afterwards.
// ----------------------------------------------------------------------------
module feedback_delay_reverb #(
  parameter int CHANNELS  = 2,
  parameter int MAX_DELAY = 65536
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  fdr_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output fdr_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fdr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fdr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int HEAD_W = $clog2(MAX_DELAY);
  localparam int CHAN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W = CHAN_W + HEAD_W;
  localparam int JOB_W  = $bits(fdr_pkg::job_t);
  localparam int JQ_W   = ADDR_W + JOB_W;

  fdr_pkg::cfg_t     cfg;
  logic              job_push;
  logic [ADDR_W-1:0] job_push_addr;
  fdr_pkg::job_t     job_push_data;
  logic              job_full;
  logic              job_empty;
  logic              job_pop;
  logic [JQ_W-1:0]   job_q_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_length  <= fdr_pkg::DELAY_LENGTH_RESET;
      cfg.decay_gain    <= '0;
      cfg.feedback_gain <= '0;
      cfg.effect_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fdr_pkg::REG_DELAY_LENGTH:  cfg.delay_length  <= cfg_data[fdr_pkg::LEN_W-1:0];
        fdr_pkg::REG_DECAY_GAIN:    cfg.decay_gain    <= cfg_data[fdr_pkg::GAIN_W-1:0];
        fdr_pkg::REG_FEEDBACK_GAIN: cfg.feedback_gain <= cfg_data[fdr_pkg::GAIN_W-1:0];
        fdr_pkg::REG_EFFECT_ENABLE: cfg.effect_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fdr_front #(
    .CHANNELS  (CHANNELS),
    .MAX_DELAY (MAX_DELAY)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg        (cfg),
    .job_full   (job_full),
    .job_push   (job_push),
    .job_addr   (job_push_addr),
    .job        (job_push_data)
  );

  // Job queue between front and back
  fdr_queue #(
    .WIDTH (JQ_W),
    .DEPTH (fdr_pkg::JOB_QUEUE_DEPTH)
  ) u_job_q (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data ({job_push_addr, job_push_data}),
    .pop       (job_pop),
    .pop_data  (job_q_data),
    .empty     (job_empty),
    .full      (job_full),
    .count     ()
  );

  fdr_back #(
    .CHANNELS  (CHANNELS),
    .MAX_DELAY (MAX_DELAY)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_empty    (job_empty),
    .job_pop      (job_pop),
    .job_addr     (job_q_data[JQ_W-1:JOB_W]),
    .job          (fdr_pkg::job_t'(job_q_data[JOB_W-1:0])),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ rtl/fdr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback delay reverb port checker
// Concurrent checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`include "feedback_delay_reverb_macros.svh"

module fdr_checker #(
  parameter int CHANNELS = 2
) (
  input logic             clk,
  input logic             rst,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input fdr_pkg::result_t result,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  // Queues come out of reset empty
  `FDR_ASSERT_RESET(a_reset_no_result, rst, !result_valid, "result valid after reset")
  `FDR_ASSERT_RESET(a_reset_no_stall, rst, !item_stall, "input stalled after reset")

  // Only in-range channels produce results
  `FDR_ASSERT_IMPL(a_channel_range, result_valid, 32'(result.channel_out) < CHANNELS, "result channel out of range")

  // Register writes are never held off
  `FDR_ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

  // A stalled result transaction holds
  `FDR_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

endmodule

bind feedback_delay_reverb fdr_checker #(.CHANNELS(CHANNELS)) u_fdr_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback delay reverb testbench
// Drives sample and flush transactions with random idling on both sides and
// checks every output sample against a predicted echo mix. The prediction
// keeps its own copy of the delay rings, heads and registers.
// ----------------------------------------------------------------------------
module tb_top;
  import fdr_pkg::*;

  localparam int N_CH        = 2;
  localparam int RING_MAX    = 65536;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = -24'sh800000;

  // Predicts the echo mix and checks each output sample in order
  class reverb_checker;
    logic signed [SAMPLE_W-1:0] ring_mem [int];
    int               ring_head [N_CH];
    logic [LEN_W-1:0]  len_reg;
    logic [GAIN_W-1:0] decay_reg;
    logic [GAIN_W-1:0] fb_reg;
    logic              en_reg;
    result_t           wet_expected [$];
    int errors, items_in, results_ok, flushes, dropped;

    function new();
      len_reg   = DELAY_LENGTH_RESET;
      decay_reg = '0;
      fb_reg    = '0;
      en_reg    = 1'b0;
      foreach (ring_head[i]) ring_head[i] = 0;
    endfunction

    // x + gain*d, product rounded half up at 2^-15, saturated to 24 bits
    function logic signed [SAMPLE_W-1:0] mix(logic signed [SAMPLE_W-1:0] x,
                                             logic signed [SAMPLE_W-1:0] d,
                                             logic [GAIN_W-1:0] g);
      longint scaled, total;
      scaled = (longint'(d) * longint'(g) + 16384) >>> 15;
      total  = longint'(x) + scaled;
      if (total > longint'(S_MAX)) return S_MAX;
      if (total < longint'(S_MIN)) return S_MIN;
      return total[SAMPLE_W-1:0];
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DELAY_LENGTH:  len_reg   = data[LEN_W-1:0];
        REG_DECAY_GAIN:    decay_reg = data[GAIN_W-1:0];
        REG_FEEDBACK_GAIN: fb_reg    = data[GAIN_W-1:0];
        REG_EFFECT_ENABLE: en_reg    = data[0];
        default: ;
      endcase
    endfunction

    function void take_item(item_t it);
      int len, hd, slot, ch;
      logic signed [SAMPLE_W-1:0] d, wet;
      result_t r;
      items_in++;
      if (it.op == OP_FLUSH) begin
        flushes++;
        ring_mem.delete();
        foreach (ring_head[i]) ring_head[i] = 0;
        return;
      end
      ch = int'(it.channel_in);
      if (ch >= N_CH) begin
        dropped++;
        return;
      end
      len = int'(len_reg);
      if (len == 0) len = 1;
      if (len > RING_MAX) len = RING_MAX;
      // head left past the ring by a length change restarts at slot 0
      hd = ring_head[ch];
      if (hd >= len) hd = 0;
      slot = ch * RING_MAX + hd;
      d = ring_mem.exists(slot) ? ring_mem[slot] : '0;
      wet = en_reg ? mix(it.sample_in, d, decay_reg) : it.sample_in;
      ring_mem[slot] = mix(it.sample_in, d, fb_reg);
      hd++;
      if (hd >= len) hd = 0;
      ring_head[ch] = hd;
      r.channel_out = it.channel_in;
      r.sample_out  = wet;
      wet_expected.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_output(result_t got);
      result_t exp_r;
      if (wet_expected.size() == 0) begin
        report($sformatf("output ch %0d sample %0d with nothing outstanding",
                         got.channel_out, got.sample_out));
        return;
      end
      exp_r = wet_expected.pop_front();
      if (got.channel_out !== exp_r.channel_out)
        report($sformatf("output %0d channel %0d, want %0d",
                         results_ok, got.channel_out, exp_r.channel_out));
      if (got.sample_out !== exp_r.sample_out)
        report($sformatf("output %0d sample %0d, want %0d",
                         results_ok, got.sample_out, exp_r.sample_out));
      results_ok++;
    endtask

    function int pending();
      return wet_expected.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item_data = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  reverb_checker sb = new();
  int send_max   = 0;
  int recv_max   = 0;
  int hold_cycles = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  feedback_delay_reverb #(
    .CHANNELS (N_CH),
    .MAX_DELAY(RING_MAX)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d outputs outstanding",
               cycle_count, sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  // Output side: random stall before each transaction, long hold on request
  initial begin : receiver
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = $urandom_range(0, recv_max);
      end
      repeat (n) begin
        @(negedge clk);
        result_stall <= 1'b1;
      end
      @(negedge clk);
      result_stall <= 1'b0;
      do @(posedge clk); while (result_valid !== 1'b1);
      sb.check_output(result_data);
    end
  end

  task send(logic op, int ch, logic signed [SAMPLE_W-1:0] x);
    item_t it;
    it.op = op;
    it.channel_in = ch[CHAN_FIELD_W-1:0];
    it.sample_in = x;
    repeat ($urandom_range(0, send_max)) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item_data  <= it;
    do @(posedge clk); while (item_stall !== 1'b0);
    sb.take_item(it);
  endtask

  // Drop valid, drain all outstanding outputs, then let the pipe settle
  task wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_reg(logic [CFG_INDEX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reg(idx, data[CFG_DATA_W-1:0]);
    cfg_writes++;
  endtask

  task apply_setting(int len, int decay, int fb, int en);
    write_reg(REG_DELAY_LENGTH, len);
    write_reg(REG_DECAY_GAIN, decay);
    write_reg(REG_FEEDBACK_GAIN, fb);
    write_reg(REG_EFFECT_ENABLE, en);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function logic signed [SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    int s;
    r = $urandom();
    case ($urandom_range(0, 5))
      0: return S_MAX;
      1: return S_MIN;
      2: begin
        s = int'($urandom_range(0, 64)) - 32;
        return s[SAMPLE_W-1:0];
      end
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  function int pick_gain();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return 32768;
      3: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Main stimulus: directed corners, then random setting phases
  initial begin : stimulus
    int lens [10];
    int len;
    lens = '{1, 2, 3, 4, 7, 16, 0, 65536, 131071, 1};
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: dry output, extremes, out-of-range channels, flush
    send_max = 2;
    recv_max = 2;
    send(OP_SAMPLE, 0, S_MAX);
    send(OP_SAMPLE, 1, S_MIN);
    send(OP_SAMPLE, 7, S_MAX);
    send(OP_SAMPLE, 2, 24'sd1234);
    send(OP_FLUSH, 0, '0);

    // Unity decay and near-double feedback drive both rails into saturation
    wait_idle();
    apply_setting(1, 32768, 65535, 1);
    send(OP_SAMPLE, 0, S_MAX);
    send(OP_SAMPLE, 0, S_MAX);
    send(OP_SAMPLE, 1, S_MIN);
    send(OP_SAMPLE, 1, S_MIN);
    send(OP_SAMPLE, 0, '0);

    // Zero length acts as one; tiny gains probe rounding
    wait_idle();
    apply_setting(0, 1, 1, 1);
    send(OP_SAMPLE, 1, '0);
    send(OP_SAMPLE, 1, -24'sd5);

    // Shrink the ring without a flush so a head lands past its end
    wait_idle();
    apply_setting(5, 16384, 49152, 1);
    repeat (4) send(OP_SAMPLE, 0, pick_sample());
    wait_idle();
    apply_setting(2, 16384, 49152, 1);
    send(OP_SAMPLE, 0, 24'sd1000);
    send(OP_SAMPLE, 0, -24'sd1000);
    send(OP_SAMPLE, 1, 24'sd77);

    // Length above the ring size clamps; effect off with nonzero gains
    wait_idle();
    apply_setting(131071, 40000, 30000, 0);
    send(OP_SAMPLE, 0, 24'sd42);
    send(OP_SAMPLE, 1, '0);
    send(OP_FLUSH, 7, S_MIN);

    // Random phases, each with its own setting and idling pattern
    lens[9] = $urandom_range(1, 32);
    for (int p = 0; p < 10; p++) begin
      len = lens[p];
      case (p % 3)
        0: begin
          send_max = 12;
          recv_max = 12;
        end
        1: begin
          send_max = 0;
          recv_max = 0;
        end
        default: begin
          send_max = 3;
          recv_max = 12;
        end
      endcase
      wait_idle();
      apply_setting(len, pick_gain(), pick_gain(), $urandom_range(0, 1));
      if ($urandom_range(0, 3) != 0)
        send(OP_FLUSH, $urandom_range(0, 7), pick_sample());
      for (int i = 0; i < 50; i++) begin
        // back pressure: output held off while input streams at full rate
        if (p == 3 && i == 10) begin
          send_max = 0;
          hold_cycles = 150;
        end
        // input pauses until every pending output has drained
        if (p == 5 && i == 25) wait_idle();
        if ($urandom_range(0, 39) == 0)
          send(OP_FLUSH, $urandom_range(0, 7), pick_sample());
        else if ($urandom_range(0, 9) == 0)
          send(OP_SAMPLE, $urandom_range(0, 7), pick_sample());
        else
          send(OP_SAMPLE, $urandom_range(0, N_CH - 1), pick_sample());
      end
    end

    wait_idle();
    $display("Sent %0d transactions (%0d flushes, %0d on absent channels), %0d register writes",
             sb.items_in, sb.flushes, sb.dropped, cfg_writes);
    $display("Compared %0d output samples over ring lengths 0..131071, %0d errors",
             sb.results_ok, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
